### sv/afp_pkg.sv
// Shared types and constants of the audio to FM period-word converter.
// No dependencies; every other file imports this package.
package afp_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic [31:0]        word_t;

    localparam int CARRIER_W   = 27;
    localparam int DEVIATION_W = 24;
    localparam int RATE_W      = 24;
    localparam int CFG_W       = 27;
    localparam int CFG_IDX_W   = 2;

    localparam int Q15_SHIFT       = 15;
    localparam int PERIOD_OFFSET   = 3;
    localparam int MIN_HALF_PERIOD = 1;
    localparam int MIN_REPEAT      = 2;
    localparam word_t MAX_WORD     = 32'hFFFF_FFFF;

    // Signed Q15 frequency: carrier term below 2^42, deviation term below 2^39
    localparam int FREQ_W = 45;
    // Twice a positive frequency
    localparam int DEN1_W = 44;
    // Sample rate times (P + 3)
    localparam int DEN2_W = 57;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CARRIER   = 2'd0,
        REG_DEVIATION = 2'd1,
        REG_RATE      = 2'd2
    } cfg_reg_t;

endpackage

### sv/afp_if.sv
// Valid/ready channel interfaces for samples in and period words out.
// Depends on afp_pkg for the payload types.
interface afp_sample_if
    import afp_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink   (input valid, input audio_sample, output ready);
endinterface

interface afp_word_if
    import afp_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t half_period;
    word_t repeat_count;
    logic  freq_invalid;

    modport source (output valid, output half_period, output repeat_count,
                    output freq_invalid, input ready);
    modport sink   (input valid, input half_period, input repeat_count,
                    input freq_invalid, output ready);
endinterface

### sv/afp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on afp_pkg only by house convention; widths come from parameters.
module afp_div_pipe
    import afp_pkg::*;
#(
    parameter int NW = 45,
    parameter int DW = 44,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_vld,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          p_vld;
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_num;
        logic [NW-1:0] p_quo;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic [DW:0]   trial;
        logic          fits;
        logic [DW-1:0] rem_next;

        // Select the previous stage, or the pipe inputs for the first one
        if (k == 0) begin : g_first
            assign p_vld  = in_vld;
            assign p_rem  = '0;
            assign p_num  = num;
            assign p_quo  = '0;
            assign p_den  = den;
            assign p_side = side;
        end else begin : g_next
            assign p_vld  = vld_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_num  = num_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        // Shift in the next numerator bit and try the subtraction
        always_comb
        begin
            trial    = {p_rem, p_num[NW-1]};
            fits     = trial >= {1'b0, p_den};
            rem_next = fits ? DW'(trial - {1'b0, p_den}) : DW'(trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= {p_num[NW-2:0], 1'b0};
                quo_reg[k]  <= {p_quo[NW-2:0], fits};
                den_reg[k]  <= p_den;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_vld  = vld_reg[NW-1];
    assign quo      = quo_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

### sv/audio_to_fm_period_words.sv
// Top level of the audio to FM period-word converter.
// Depends on afp_pkg, afp_if and afp_div_pipe.
//
// Takes one signed audio sample per cycle unless held, and delivers one
// (half_period, repeat_count, freq_invalid) transaction per sample, in order,
// through stage A, the first divider, stages C and D, the second divider and
// the output register. The dividers retire one quotient bit per stage: NW1 is
// the bit width of CLOCK_HZ*32768 (43 at 200 MHz) and NW2 that of CLOCK_HZ (28
// at 200 MHz). The whole pipeline advances together and holds while the output register is full and not taken.
// Write configuration only while no transaction is in flight.
module audio_to_fm_period_words
    import afp_pkg::*;
#(
    parameter int CLOCK_HZ = 200000000
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    afp_sample_if.sink           samples,
    afp_word_if.source           words
);

    localparam longint NUM1 = longint'(CLOCK_HZ) * 64'd32768;
    localparam int     NW1  = $clog2(NUM1 + 1);
    localparam int     NW2  = $clog2(longint'(CLOCK_HZ) + 1);

    logic [CARRIER_W-1:0]   carrier_reg;
    logic [DEVIATION_W-1:0] deviation_reg;
    logic [RATE_W-1:0]      rate_reg;

    logic en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg   <= CARRIER_W'(1000000);
            deviation_reg <= DEVIATION_W'(50000);
            rate_reg      <= RATE_W'(192000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CARRIER:   carrier_reg   <= cfg_data[CARRIER_W-1:0];
                REG_DEVIATION: deviation_reg <= cfg_data[DEVIATION_W-1:0];
                REG_RATE:      rate_reg      <= cfg_data[RATE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Stage A: instantaneous frequency in Q15
    logic                     a_vld_reg;
    logic signed [FREQ_W-1:0] freq_reg;
    logic signed [FREQ_W-1:0] freq_next;
    logic signed [40:0]       dev_term;

    always_comb
    begin
        dev_term  = $signed({1'b0, deviation_reg}) * samples.audio_sample;
        freq_next = $signed({3'b000, carrier_reg, 15'b0}) + FREQ_W'(dev_term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            freq_reg <= freq_next;
        end
    end

    // First divider: CLOCK_HZ*32768 / (2*F)
    logic              f_bad;
    logic [DEN1_W-1:0] den1;
    logic              d1_vld;
    logic [NW1-1:0]    q1;
    logic              d1_bad;

    always_comb
    begin
        f_bad = (freq_reg <= 0);
        den1  = f_bad ? DEN1_W'(1) : {freq_reg[DEN1_W-2:0], 1'b0};
    end

    afp_div_pipe #(.NW(NW1), .DW(DEN1_W), .SW(1)) u_div_period
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (a_vld_reg),
        .num      (NW1'(NUM1)),
        .den      (den1),
        .side     (f_bad),
        .out_vld  (d1_vld),
        .quo      (q1),
        .side_out (d1_bad)
    );

    // Stage C: drop the offset, clamp and saturate the half period
    logic           c_vld_reg;
    word_t          p_reg;
    logic           c_bad_reg;
    word_t          p_next;
    logic [NW1-1:0] q1_off;

    always_comb
    begin
        q1_off = q1 - NW1'(PERIOD_OFFSET);
        if (d1_bad)
            p_next = MAX_WORD;
        else if (q1 < NW1'(PERIOD_OFFSET + MIN_HALF_PERIOD))
            p_next = word_t'(MIN_HALF_PERIOD);
        else if (q1_off[NW1-1:32] != '0)
            p_next = MAX_WORD;
        else
            p_next = q1_off[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            c_bad_reg <= d1_bad;
        end
    end

    // Stage D: repeat divisor, sample rate times full period count
    logic              dd_vld_reg;
    logic [DEN2_W-1:0] den2_reg;
    word_t             dd_p_reg;
    logic              dd_bad_reg;
    logic              dd_zero_reg;
    logic [32:0]       p_full;

    assign p_full = {1'b0, p_reg} + 33'(PERIOD_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            dd_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den2_reg    <= rate_reg * p_full;
            dd_p_reg    <= p_reg;
            dd_bad_reg  <= c_bad_reg;
            dd_zero_reg <= (rate_reg == '0);
        end
    end

    // Second divider: CLOCK_HZ / (rate*(P+3))
    logic           d2_vld;
    logic [NW2-1:0] q2;
    logic [33:0]    d2_side;

    afp_div_pipe #(.NW(NW2), .DW(DEN2_W), .SW(34)) u_div_repeat
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (dd_vld_reg),
        .num      (NW2'(CLOCK_HZ)),
        .den      (den2_reg),
        .side     ({dd_zero_reg, dd_bad_reg, dd_p_reg}),
        .out_vld  (d2_vld),
        .quo      (q2),
        .side_out (d2_side)
    );

    // Output register: clamp the repeat count
    logic  out_vld_reg;
    word_t hp_reg;
    word_t rc_reg;
    logic  inv_reg;
    word_t x_next;

    always_comb
    begin
        if (d2_side[33])
            x_next = MAX_WORD;
        else if (32'(q2) < word_t'(MIN_REPEAT))
            x_next = word_t'(MIN_REPEAT);
        else
            x_next = 32'(q2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp_reg  <= d2_side[31:0];
            inv_reg <= d2_side[32];
            rc_reg  <= x_next;
        end
    end

    // Advance the whole pipeline unless the output is held
    assign en = !out_vld_reg || words.ready;

    assign samples.ready      = en;
    assign words.valid        = out_vld_reg;
    assign words.half_period  = hp_reg;
    assign words.repeat_count = rc_reg;
    assign words.freq_invalid = inv_reg;

endmodule
